>>> sv/swa_pkg.sv
// Package: sizes, types and codes shared by the sliding window average block.
`timescale 1ns / 1ps
package swa_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int DATA_W     = 32;
	localparam int WIN_W      = 7;
	localparam int ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = DATA_W + ADDR_W;
	localparam int STEP_W     = $clog2(SUM_W + 1);
	localparam int PADDR_W    = 3;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);

	// Register index, taken from the word address bit paddr[2]
	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic signed [SUM_W-1:0]  dividend;
		logic [CNT_W-1:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> sv/sliding_window_average_core.sv
// Sliding window average: ring buffer in RAM, running sum, iterative divide.
`timescale 1ns / 1ps
// Usage
//   Input channel: sample_value (signed Q16.16) and sample_invalid, handshake
//   in_valid / in_stall. A request is taken when in_valid is high and in_stall
//   low. Output channel: window_average, handshake out_valid / out_stall.
//   Samples are held in a 64-entry RAM used as a ring, with a running sum.
//   While fewer than window_size samples are held, a valid request is simply
//   appended (in_stall stays low, no result). An invalid one is dropped. Once
//   full, the request yields sum / window_size truncated toward zero; the
//   oldest sample leaves, the new one enters if valid. A full request reads
//   the oldest sample and starts the divider, which works out the quotient
//   bit by bit while the ring update runs alongside; then come the done
//   hand-off and the output load. in_stall is high after acceptance until the
//   result is loaded, so no new request is taken while a divide is running.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a second result waits in the divider until the first has
//   been taken, with in_stall high.
//   window_size is written over APB at byte address 0 from pwdata[6:0] (reset
//   32, 0 acts as 1, over 64 as 64). Write it only when the block is idle.
//   Reset empties the buffer (count, pointer and sum cleared) at once: no
//   clearing pass, as an entry is never read before it has been written.
module sliding_window_average_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [swa_pkg::DATA_W-1:0]   sample_value,
	input  logic                                sample_invalid,
	// results
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [swa_pkg::DATA_W-1:0]   window_average,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swa_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	swa_pkg::state_t                   state_q, state_d;

	logic [swa_pkg::WIN_W-1:0]         window_size_q;
	logic [swa_pkg::ADDR_W-1:0]        oldest_q;
	logic [swa_pkg::CNT_W-1:0]         count_q;
	logic signed [swa_pkg::SUM_W-1:0]  sum_q;
	logic signed [swa_pkg::DATA_W-1:0] samp_q;
	logic                              inv_q;
	logic                              out_valid_q;
	logic [swa_pkg::DATA_W-1:0]        out_q;

	logic [swa_pkg::CNT_W-1:0]         win_eff;
	logic                              full;
	logic                              in_acc;
	logic                              out_free;
	logic                              cfg_wr;
	logic [swa_pkg::CNT_W:0]           slot_sum;
	logic [swa_pkg::ADDR_W-1:0]        slot;
	logic [swa_pkg::ADDR_W-1:0]        oldest_inc;

	logic                              ram_we;
	logic [swa_pkg::ADDR_W-1:0]        ram_waddr;
	logic [swa_pkg::DATA_W-1:0]        ram_wdata;
	logic                              ram_re;
	logic [swa_pkg::DATA_W-1:0]        ram_rdata;

	swa_pkg::div_req_t                 div_req;
	swa_pkg::div_rsp_t                 div_rsp;

	// ---- configuration ---------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swa_pkg::WIN_RESET;
		end else if (cfg_wr && (paddr[2] == swa_pkg::REG_WINDOW_SIZE)) begin
			window_size_q <= pwdata[swa_pkg::WIN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == swa_pkg::REG_WINDOW_SIZE) begin
			prdata[swa_pkg::WIN_W-1:0] = window_size_q;
		end
	end

	// Effective window: clamp to 1..MAX_WINDOW
	always_comb begin
		if (window_size_q == '0) begin
			win_eff = swa_pkg::CNT_W'(1);
		end else if (32'(window_size_q) > 32'(swa_pkg::MAX_WINDOW)) begin
			win_eff = swa_pkg::CNT_W'(swa_pkg::MAX_WINDOW);
		end else begin
			win_eff = swa_pkg::CNT_W'(window_size_q);
		end
	end

	assign full = count_q >= win_eff;

	// ---- ring addressing -------------------------------------------------
	// Append slot is oldest + count; across a full step it is the same entry
	// (oldest moves up by one, count down by one).
	always_comb begin
		slot_sum = {1'b0, swa_pkg::CNT_W'(oldest_q)} + {1'b0, count_q};
		if (slot_sum >= (swa_pkg::CNT_W+1)'(swa_pkg::MAX_WINDOW)) begin
			slot_sum = slot_sum - (swa_pkg::CNT_W+1)'(swa_pkg::MAX_WINDOW);
		end
		slot = slot_sum[swa_pkg::ADDR_W-1:0];
		if (32'(oldest_q) == 32'(swa_pkg::MAX_WINDOW - 1)) begin
			oldest_inc = '0;
		end else begin
			oldest_inc = oldest_q + swa_pkg::ADDR_W'(1);
		end
	end

	// ---- handshakes ------------------------------------------------------
	assign in_stall  = (state_q != swa_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign window_average = out_q;

	// ---- sequencer -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ram_we        = 1'b0;
		ram_waddr     = slot;
		ram_wdata     = sample_value;
		ram_re        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_q;
		div_req.divisor  = win_eff;
		unique case (state_q)
			swa_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (full) begin
						// fetch the oldest sample, divide the current sum
						ram_re        = 1'b1;
						div_req.start = 1'b1;
						state_d       = swa_pkg::ST_UPDATE;
					end else begin
						ram_we = !sample_invalid;
					end
				end
			end
			swa_pkg::ST_UPDATE: begin
				ram_we    = !inv_q;
				ram_wdata = samp_q;
				state_d   = swa_pkg::ST_DIV;
			end
			swa_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = swa_pkg::ST_EMIT;
				end
			end
			swa_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = swa_pkg::ST_IDLE;
				end
			end
			default: state_d = swa_pkg::ST_IDLE;
		endcase
	end

	// ---- ring state: pointer, count, sum ---------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else if (state_q == swa_pkg::ST_IDLE && in_acc && !full && !sample_invalid) begin
			count_q <= count_q + swa_pkg::CNT_W'(1);
			sum_q   <= sum_q + swa_pkg::SUM_W'(sample_value);
		end else if (state_q == swa_pkg::ST_UPDATE) begin
			oldest_q <= oldest_inc;
			if (inv_q) begin
				count_q <= count_q - swa_pkg::CNT_W'(1);
				sum_q   <= sum_q - swa_pkg::SUM_W'($signed(ram_rdata));
			end else begin
				sum_q   <= sum_q - swa_pkg::SUM_W'($signed(ram_rdata))
				                 + swa_pkg::SUM_W'(samp_q);
			end
		end
	end

	// request payload held for the update cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= sample_value;
			inv_q  <= sample_invalid;
		end
	end

	// ---- output register -------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == swa_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == swa_pkg::ST_EMIT && out_free) begin
			out_q <= div_rsp.quotient;
		end
	end

	// ---- units -----------------------------------------------------------
	swa_ram #(
		.WIDTH (swa_pkg::DATA_W),
		.DEPTH (swa_pkg::MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	swa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

>>> sv/swa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module swa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/swa_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, saturating result.
`timescale 1ns / 1ps
module swa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  swa_pkg::div_req_t req,
	output swa_pkg::div_rsp_t rsp
);

	localparam logic [swa_pkg::SUM_W-1:0] LIM = swa_pkg::SUM_W'(1) << (swa_pkg::DATA_W - 1);

	logic                           busy_q;
	logic                           done_q;
	logic [swa_pkg::STEP_W-1:0]     step_q;
	logic [swa_pkg::CNT_W-1:0]      rem_q;
	logic [swa_pkg::SUM_W-1:0]      mag_q;
	logic                           neg_q;
	logic [swa_pkg::CNT_W-1:0]      dvs_q;

	logic [swa_pkg::CNT_W:0]        shifted;
	logic [swa_pkg::CNT_W:0]        diff;
	logic                           fits;
	logic [swa_pkg::SUM_W-1:0]      neg_mag;

	always_comb begin
		shifted = {rem_q, mag_q[swa_pkg::SUM_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
		neg_mag = ~mag_q + swa_pkg::SUM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + swa_pkg::STEP_W'(1);
			if (step_q == swa_pkg::STEP_W'(swa_pkg::SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: magnitude shifts left, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			neg_q <= req.dividend[swa_pkg::SUM_W-1];
			mag_q <= req.dividend[swa_pkg::SUM_W-1] ? (~req.dividend + swa_pkg::SUM_W'(1))
			                                         : req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[swa_pkg::CNT_W-1:0] : shifted[swa_pkg::CNT_W-1:0];
			mag_q <= {mag_q[swa_pkg::SUM_W-2:0], fits};
		end
	end

	// Sign restore and clamp to the 32-bit signed range
	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			rsp.quotient = (mag_q > LIM) ? {1'b1, {(swa_pkg::DATA_W-1){1'b0}}}
			                             : neg_mag[swa_pkg::DATA_W-1:0];
		end else begin
			rsp.quotient = (mag_q >= LIM) ? {1'b0, {(swa_pkg::DATA_W-1){1'b1}}}
			                              : mag_q[swa_pkg::DATA_W-1:0];
		end
	end

endmodule

>>> sv/swa_checker.sv
// Port-level checker for the sliding window average block, with its bind.
`timescale 1ns / 1ps
module swa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic signed [swa_pkg::DATA_W-1:0]   sample_value,
	input logic                                sample_invalid,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [swa_pkg::DATA_W-1:0]   window_average,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [swa_pkg::PADDR_W-1:0]         paddr,
	input logic [31:0]                         pwdata,
	input logic [31:0]                         prdata,
	input logic                                pready
);

	// held request stays put until taken
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_value) && $stable(sample_invalid))
		else $error("request changed while stalled");

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_average))
		else $error("result changed while stalled");

	// a new result only follows a period with the input held off
	a_rose_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a divide in progress");

	// a full request keeps the input stalled for the divide
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("input released before the divide could finish");

	// window register reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == swa_pkg::REG_WINDOW_SIZE)
		##1 (paddr[2] == swa_pkg::REG_WINDOW_SIZE)
		|-> prdata[swa_pkg::WIN_W-1:0] == $past(pwdata[swa_pkg::WIN_W-1:0]))
		else $error("window_size readback mismatch");

endmodule

bind sliding_window_average_core swa_checker u_swa_checker (.*);

>>> test/testbench.sv
// Testbench for the sliding window average core: directed table, then random requests.
`timescale 1ns / 1ps
module testbench;
	import swa_pkg::*;

	// Run length and pacing
	localparam int CYCLE_LIMIT       = 1000000;
	localparam int SETTLE_CYCLES     = 50;
	localparam int DRAIN_CYCLES      = 60;
	localparam int HOLD_OFF_CYCLES   = 500;
	localparam int ITEMS_PER_SETTING = 138;

	// Window settings for the random part: four per idling pattern. Includes the
	// extremes (0 acts as 1, 127 acts as 64) and a drop from 64 to tiny windows.
	localparam logic [WIN_W-1:0] WINDOW_PLAN [12] = '{
		7'd2, 7'd64, 7'd0, 7'd32,
		7'd127, 7'd1, 7'd17, 7'd5,
		7'd64, 7'd3, 7'd1, 7'd9
	};

	typedef enum logic {
		ROW_WRITE,   // write window_size, value holds the new setting
		ROW_SAMPLE   // send one request
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [DATA_W-1:0] value;
		logic              invalid;
		logic              typed;    // result typed in below rather than predicted
		logic [DATA_W-1:0] avg;
	} stim_row_t;

	// Directed table. Typed results are the ones that are obvious by hand:
	// window of one, and saturation once the window has been shrunk under a
	// buffer of full-scale samples.
	localparam stim_row_t DIRECTED_ROWS [25] = '{
		'{ROW_WRITE,  32'd1,          1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'h7FFFFFFF,   1'b0, 1'b0, 32'h0},        // fills the window
		'{ROW_SAMPLE, 32'h80000000,   1'b0, 1'b1, 32'h7FFFFFFF},
		'{ROW_SAMPLE, 32'h00000000,   1'b1, 1'b1, 32'h80000000}, // NaN empties the buffer
		'{ROW_SAMPLE, 32'h00000005,   1'b1, 1'b0, 32'h0},        // NaN on empty: ignored
		'{ROW_SAMPLE, 32'd12345,      1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'hFFFFFFFF,   1'b0, 1'b1, 32'd12345},
		'{ROW_WRITE,  32'd0,          1'b0, 1'b0, 32'h0},        // zero acts as one
		'{ROW_SAMPLE, 32'h00000003,   1'b0, 1'b1, 32'hFFFFFFFF},
		'{ROW_SAMPLE, 32'h00000000,   1'b0, 1'b1, 32'h00000003},
		'{ROW_WRITE,  32'd3,          1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'h7FFFFFFF,   1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'h7FFFFFFF,   1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'h7FFFFFFF,   1'b0, 1'b0, 32'h0},        // predicted: 2*max/3
		'{ROW_WRITE,  32'd1,          1'b0, 1'b0, 32'h0},        // three held, window one
		'{ROW_SAMPLE, 32'h00000001,   1'b1, 1'b1, 32'h7FFFFFFF}, // saturates high
		'{ROW_SAMPLE, 32'h80000000,   1'b0, 1'b1, 32'h7FFFFFFF},
		'{ROW_SAMPLE, 32'h80000000,   1'b0, 1'b1, 32'hFFFFFFFF},
		'{ROW_SAMPLE, 32'h80000000,   1'b0, 1'b1, 32'h80000000}, // saturates low
		'{ROW_SAMPLE, 32'h00000000,   1'b1, 1'b1, 32'h80000000},
		'{ROW_SAMPLE, 32'h00000000,   1'b1, 1'b1, 32'h80000000}, // buffer empty again
		'{ROW_WRITE,  32'd127,        1'b0, 1'b0, 32'h0},        // clamps to 64
		'{ROW_SAMPLE, 32'h55555555,   1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'hAAAAAAAA,   1'b0, 1'b0, 32'h0},
		'{ROW_SAMPLE, 32'h00000007,   1'b1, 1'b0, 32'h0}
	};

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// Block inputs, all known from time zero
	logic                     in_valid       = 1'b0;
	logic signed [DATA_W-1:0] sample_value   = '0;
	logic                     sample_invalid = 1'b0;
	logic                     out_stall      = 1'b0;
	logic                     psel           = 1'b0;
	logic                     penable        = 1'b0;
	logic                     pwrite         = 1'b0;
	logic [PADDR_W-1:0]       paddr          = '0;
	logic [31:0]              pwdata         = '0;

	// Block outputs
	logic                     in_stall;
	logic                     out_valid;
	logic signed [DATA_W-1:0] window_average;
	logic [31:0]              prdata;
	logic                     pready;

	sliding_window_average_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.sample_invalid (sample_invalid),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_average (window_average),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Own copy of the block's state, updated per accepted request
	logic signed [DATA_W-1:0] win_store [MAX_WINDOW];
	logic [ADDR_W-1:0]        win_head  = '0;
	logic [CNT_W-1:0]         win_count = '0;
	logic signed [SUM_W-1:0]  win_sum   = '0;
	logic [WIN_W-1:0]         cfg_window = WIN_RESET;

	logic [DATA_W-1:0] pending_averages [$];
	int                failures    = 0;
	int                cycle_count = 0;
	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;

	// Receiver hold-off: main flips the toggle, the receiver counts the cycles
	bit hold_toggle = 1'b0;
	bit hold_seen   = 1'b0;
	int hold_left   = 0;

	function automatic int unsigned effective_window();
		if (cfg_window == 0)
			return 1;
		if (cfg_window > MAX_WINDOW)
			return MAX_WINDOW;
		return 32'(cfg_window);
	endfunction

	// One step of the moving average. Full when the count reaches the window,
	// even if the window has since been made smaller than the count.
	function automatic bit predict_average(input logic signed [DATA_W-1:0] v,
		input bit inv, output logic [DATA_W-1:0] avg);
		int unsigned       w;
		longint            quot;
		logic [ADDR_W-1:0] slot;
		bit                full;
		w    = effective_window();
		full = (win_count >= w);
		avg  = '0;
		if (full) begin
			quot = longint'(win_sum) / longint'(w);
			if (quot > 64'sd2147483647)
				avg = 32'h7FFFFFFF;
			else if (quot < -64'sd2147483648)
				avg = 32'h80000000;
			else
				avg = quot[DATA_W-1:0];
			win_sum   = win_sum - SUM_W'(win_store[win_head]);
			win_head  = win_head + 1'b1;
			win_count = win_count - 1'b1;
		end
		if (!inv) begin
			slot            = win_head + ADDR_W'(win_count);
			win_store[slot] = v;
			win_count       = win_count + 1'b1;
			win_sum         = win_sum + SUM_W'(v);
		end
		return full;
	endfunction

	// Spread of sample values: full random, small, rails and near-rails
	function automatic logic [DATA_W-1:0] draw_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(32'h00200000) - 32'h00100000;
			6: begin
				case ($urandom_range(4))
					0:       return 32'h7FFFFFFF;
					1:       return 32'h80000000;
					2:       return 32'h00000000;
					3:       return 32'hFFFFFFFF;
					default: return 32'h00010000;
				endcase
			end
			7:          return 32'h7FFFFFFF - $urandom_range(255);
			8:          return 32'h80000000 + $urandom_range(255);
			default:    return $urandom & 32'h0001FFFF;
		endcase
	endfunction

	// Offer one request, holding it until the block takes it, then predict
	task automatic send_request(input logic [DATA_W-1:0] v, input bit inv,
		input bit typed, input logic [DATA_W-1:0] typed_avg);
		logic [DATA_W-1:0] avg;
		bit                got;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		sample_value   <= v;
		sample_invalid <= inv;
		do @(posedge clk); while (in_stall);
		got = predict_average(v, inv, avg);
		if (typed)
			pending_averages = {pending_averages, typed_avg};
		else if (got)
			pending_averages = {pending_averages, avg};
	endtask

	task automatic stop_requests();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Idle: every result in, then room for a request that yields none
	task automatic settle();
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase; upper data bits are junk the register must drop
	task automatic write_window_size(input logic [WIN_W-1:0] w);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_WINDOW_SIZE);
		pwdata  <= {(32 - WIN_W)'($urandom), w};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_window = w;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: random stalls per idling pattern, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Result checker: each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_averages.size() == 0) begin
				$error("window_average: unexpected result, actual %0d", window_average);
				failures++;
			end else begin
				if (window_average !== pending_averages[0]) begin
					$error("window_average mismatch: expected %0d, actual %0d",
						$signed(pending_averages[0]), window_average);
					failures++;
				end
				void'(pending_averages.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int                counted;
		logic [DATA_W-1:0] v;
		bit                inv;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register reads back its reset value
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(4 * REG_WINDOW_SIZE);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(WIN_RESET)) begin
			$error("window_size read mismatch: expected %0d, actual %0d", WIN_RESET, prdata);
			failures++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;

		// Directed table, with light idling on the sender and heavy on the receiver
		tx_idle_pct = 8;
		rx_idle_pct = 77;
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
				stop_requests();
				settle();
				write_window_size(DIRECTED_ROWS[i].value[WIN_W-1:0]);
			end else begin
				send_request(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].invalid,
					DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].avg);
			end
		end

		// Random part: three idling patterns, four window settings each. Requests
		// the block simply ignores (NaN while not full) are not counted.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 8;
					rx_idle_pct = 77;
				end
				1: begin
					tx_idle_pct = 77;
					rx_idle_pct = 8;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				stop_requests();
				settle();
				write_window_size(WINDOW_PLAN[mode * 4 + k]);
				// window of three on a filled buffer: every request yields a result,
				// so a long hold-off backs the block up until it stalls its input
				if (mode == 2 && k == 1)
					hold_toggle = ~hold_toggle;
				counted = 0;
				while (counted < ITEMS_PER_SETTING) begin
					v   = draw_sample();
					inv = ($urandom_range(9) == 0);
					if (!inv || win_count >= effective_window())
						counted++;
					send_request(v, inv, 1'b0, '0);
				end
			end
		end

		stop_requests();
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
